// ===== rtl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the SMF track event parser.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_SYSEX = 2'd1;
  localparam logic [1:0] KIND_TEMPO = 2'd2;
  localparam logic [1:0] KIND_EOT   = 2'd3;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_PROG     = 8'hC0;
  localparam logic [7:0] ST_PRESS    = 8'hD0;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_EVENT    = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SYSDATA  = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_METADATA = 4'd8,
    PH_DONE     = 4'd9
  } smf_phase_t;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       start_of_track;
    logic       end_of_track;
  } smf_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [23:0] tempo_us;
    logic        last_of_run;
  } smf_out_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } smf_push_t;

endpackage

// ===== rtl/smf_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// smf_track_event_parser
// Parses one SMF track byte per word into channel, sysex, tempo and
// end-of-track events with absolute tick times.
//
//   port group | dir | word type  | handshake
//   in_*       | in  | smf_in_t   | in_valid / in_stall
//   out_*      | out | smf_out_t  | out_valid / out_stall
//   cfg_*      | in  | 1 bit      | cfg_wr_en, no wait
//
// A word is registered, parsed in the next cycle, and its results (up to
// two) enter an 8-entry result queue; one word per cycle is taken while the
// queue has room for two more results beyond what is in flight.
// A word's first result passes the input register, then the result queue;
// a word with a trailing end-of-track result puts two results out in turn.
// rst_n clears the parse state, the queue and sets use_file_tempo.
// ----------------------------------------------------------------------------
module smf_track_event_parser
  import smf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  smf_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output smf_out_t out_word,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  logic                in_vld_r;
  smf_in_t             in_word_r;
  logic                tempo_en_r;
  smf_push_t           push;
  smf_out_t            res0;
  smf_out_t            res1;
  smf_out_t            q_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;
  logic [FifoCntW:0]   pending;
  logic [1:0]          n_push;
  logic                pop;

  smf_parse_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_vld       (in_vld_r),
    .item           (in_word_r),
    .use_file_tempo (tempo_en_r),
    .push           (push),
    .res0           (res0),
    .res1           (res1)
  );

  // hold input while the queue might not fit two more results
  assign pending  = {1'b0, cnt_r} + (in_vld_r ? (FifoCntW+1)'(2) : '0);
  assign in_stall = pending > (FifoCntW+1)'(FifoDepth - 2);

  assign out_valid = (cnt_r != '0);
  assign out_word  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    n_push     = {1'b0, push.push0} + {1'b0, push.push1};
    wr_ptr_nxt = wr_ptr_r + FifoPtrW'(n_push);
    rd_ptr_nxt = rd_ptr_r + FifoPtrW'(pop);
    cnt_nxt    = cnt_r + FifoCntW'(n_push) - FifoCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      tempo_en_r <= 1'b1;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      in_vld_r <= in_valid && !in_stall;
      if (cfg_wr_en) begin
        tempo_en_r <= cfg_wr_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
    if (push.push0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push.push1) begin
      q_r[wr_ptr_r + FifoPtrW'(1)] <= res1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_second_is_eot: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (push.push0 && res1.kind == KIND_EOT))
    else $error("second result is not end of track");

  a_push_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> $past(in_valid && !in_stall))
    else $error("result without an accepted word");
`endif

endmodule

// ===== rtl/smf_parse_core.sv =====
// ----------------------------------------------------------------------------
// smf_parse_core
// Byte parser: delta times, running status, sysex and meta events.
// ----------------------------------------------------------------------------
module smf_parse_core
  import smf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  smf_in_t    item,
  input  logic       use_file_tempo,
  output smf_push_t  push,
  output smf_out_t   res0,
  output smf_out_t   res1
);

  smf_phase_t  phase_r, phase_c, phase_nxt;
  logic [7:0]  rs_r, rs_c, rs_nxt;
  logic [3:0]  rch_r, rch_c, rch_nxt;
  logic [27:0] acc_r, acc_c, acc_nxt;
  logic [31:0] tick_r, tick_c, tick_nxt;
  logic [27:0] rem_r, rem_c, rem_nxt;
  logic [7:0]  held_r, held_c, held_nxt;
  logic [7:0]  mkind_r, mkind_c, mkind_nxt;
  logic [23:0] tshift_r, tshift_c, tshift_nxt;
  logic [1:0]  midx_r, midx_c, midx_nxt;

  logic [7:0]  b;
  logic [27:0] acc_take;
  logic [27:0] rem_dec;
  logic        vl_done;
  logic        one_data;
  logic        byte_vld;
  logic        eot_vld;
  smf_out_t    byte_res;
  smf_out_t    eot_res;

  always_comb begin
    b        = item.track_byte;
    phase_c  = item.start_of_track ? PH_DELTA : phase_r;
    rs_c     = item.start_of_track ? 8'd0 : rs_r;
    rch_c    = item.start_of_track ? 4'd0 : rch_r;
    acc_c    = item.start_of_track ? 28'd0 : acc_r;
    tick_c   = item.start_of_track ? 32'd0 : tick_r;
    rem_c    = item.start_of_track ? 28'd0 : rem_r;
    held_c   = item.start_of_track ? 8'd0 : held_r;
    mkind_c  = item.start_of_track ? 8'd0 : mkind_r;
    tshift_c = item.start_of_track ? 24'd0 : tshift_r;
    midx_c   = item.start_of_track ? 2'd0 : midx_r;

    acc_take = {acc_c[20:0], b[6:0]};
    vl_done  = ~b[7];
    rem_dec  = rem_c - 28'd1;
    one_data = (rs_c == ST_PROG) || (rs_c == ST_PRESS);

    phase_nxt  = phase_c;
    rs_nxt     = rs_c;
    rch_nxt    = rch_c;
    acc_nxt    = acc_c;
    tick_nxt   = tick_c;
    rem_nxt    = rem_c;
    held_nxt   = held_c;
    mkind_nxt  = mkind_c;
    tshift_nxt = tshift_c;
    midx_nxt   = midx_c;

    byte_vld = 1'b0;
    byte_res = '0;

    case (phase_c)
      PH_DELTA: begin
        if (vl_done) begin
          tick_nxt  = tick_c + {4'd0, acc_take};
          acc_nxt   = 28'd0;
          phase_nxt = PH_EVENT;
        end else begin
          acc_nxt = acc_take;
        end
      end
      PH_EVENT: begin
        if (!b[7]) begin
          if (one_data) begin
            byte_vld             = 1'b1;
            byte_res.kind        = KIND_CHAN;
            byte_res.status_byte = rs_c | {4'd0, rch_c};
            byte_res.first_data  = b;
            byte_res.data_count  = 2'd1;
            phase_nxt            = PH_DELTA;
          end else begin
            held_nxt  = b;
            phase_nxt = PH_DATA2;
          end
        end else if (b == ST_SYSEX || b == ST_SYSEX_CT) begin
          rs_nxt    = 8'd0;
          acc_nxt   = 28'd0;
          phase_nxt = PH_SYSLEN;
        end else if (b == ST_META) begin
          rs_nxt    = 8'd0;
          phase_nxt = PH_METATYPE;
        end else begin
          rs_nxt    = {b[7:4], 4'd0};
          rch_nxt   = b[3:0];
          phase_nxt = PH_DATA1;
        end
      end
      PH_DATA1: begin
        if (one_data) begin
          byte_vld             = 1'b1;
          byte_res.kind        = KIND_CHAN;
          byte_res.status_byte = rs_c | {4'd0, rch_c};
          byte_res.first_data  = b;
          byte_res.data_count  = 2'd1;
          phase_nxt            = PH_DELTA;
        end else begin
          held_nxt  = b;
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        byte_vld             = 1'b1;
        byte_res.kind        = KIND_CHAN;
        byte_res.status_byte = rs_c | {4'd0, rch_c};
        byte_res.first_data  = held_c;
        byte_res.second_data = b;
        byte_res.data_count  = 2'd2;
        phase_nxt            = PH_DELTA;
      end
      PH_SYSLEN: begin
        if (vl_done) begin
          rem_nxt              = acc_take;
          acc_nxt              = 28'd0;
          byte_vld             = 1'b1;
          byte_res.kind        = KIND_SYSEX;
          byte_res.status_byte = ST_SYSEX;
          byte_res.last_of_run = (acc_take == 28'd0);
          phase_nxt            = (acc_take != 28'd0) ? PH_SYSDATA : PH_DELTA;
        end else begin
          acc_nxt = acc_take;
        end
      end
      PH_SYSDATA: begin
        rem_nxt              = rem_dec;
        byte_vld             = 1'b1;
        byte_res.kind        = KIND_SYSEX;
        byte_res.status_byte = b;
        byte_res.last_of_run = (rem_dec == 28'd0);
        if (rem_dec == 28'd0) begin
          phase_nxt = PH_DELTA;
        end
      end
      PH_METATYPE: begin
        mkind_nxt = b;
        acc_nxt   = 28'd0;
        phase_nxt = PH_METALEN;
      end
      PH_METALEN: begin
        if (vl_done) begin
          rem_nxt    = acc_take;
          acc_nxt    = 28'd0;
          midx_nxt   = 2'd0;
          tshift_nxt = 24'd0;
          phase_nxt  = (acc_take != 28'd0) ? PH_METADATA : PH_DELTA;
        end else begin
          acc_nxt = acc_take;
        end
      end
      PH_METADATA: begin
        if (mkind_c == META_TEMPO && midx_c != 2'd3) begin
          tshift_nxt = {tshift_c[15:0], b};
          midx_nxt   = midx_c + 2'd1;
          if (midx_c == 2'd2 && use_file_tempo) begin
            byte_vld          = 1'b1;
            byte_res.kind     = KIND_TEMPO;
            byte_res.tempo_us = {tshift_c[15:0], b};
          end
        end
        rem_nxt = rem_dec;
        if (rem_dec == 28'd0) begin
          phase_nxt = PH_DELTA;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DELTA;
      end
    endcase

    eot_vld = item.end_of_track && (phase_c != PH_DONE);
    if (eot_vld) begin
      phase_nxt = PH_DONE;
    end

    byte_res.tick_time = tick_nxt;
    eot_res            = '0;
    eot_res.kind       = KIND_EOT;
    eot_res.tick_time  = tick_nxt;

    push.push0 = item_vld && (byte_vld || eot_vld);
    push.push1 = item_vld && byte_vld && eot_vld;
    res0       = byte_vld ? byte_res : eot_res;
    res1       = eot_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      rs_r     <= 8'd0;
      rch_r    <= 4'd0;
      acc_r    <= 28'd0;
      tick_r   <= 32'd0;
      rem_r    <= 28'd0;
      held_r   <= 8'd0;
      mkind_r  <= 8'd0;
      tshift_r <= 24'd0;
      midx_r   <= 2'd0;
    end else if (item_vld) begin
      phase_r  <= phase_nxt;
      rs_r     <= rs_nxt;
      rch_r    <= rch_nxt;
      acc_r    <= acc_nxt;
      tick_r   <= tick_nxt;
      rem_r    <= rem_nxt;
      held_r   <= held_nxt;
      mkind_r  <= mkind_nxt;
      tshift_r <= tshift_nxt;
      midx_r   <= midx_nxt;
    end
  end

endmodule
